// ===== rtl/rgem_pkg.sv =====
`timescale 1ns / 1ps
// rgem_pkg: shared types, constants and helpers for the gradient edge marker
// no dependencies; compiled first

package rgem_pkg;

  localparam int CHAN_W       = 8;
  localparam int NUM_CHAN     = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;
  localparam int DEF_MAX_W    = 1024;
  localparam int DEF_MAX_H    = 1024;
  localparam int RST_WIDTH    = 640;
  localparam int RST_HEIGHT   = 480;
  localparam int RST_MAXCOL   = 255;
  localparam int EDGE_DIVISOR = 2000;
  localparam int SQ_W         = 2 * CHAN_W;
  localparam int PROD_W       = SQ_W + 11;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MAXCOL = 2'd2,
    REG_SPARE  = 2'd3
  } cfg_reg_e;

  // channel 0 is red, 1 green, 2 blue
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t           center;
    logic [SQ_W-1:0]  dsq;
    logic             last;
  } qent_t;

  function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/rgem_ifs.sv =====
`timescale 1ns / 1ps
// rgem_ifs: stream and configuration channel interfaces
// depends on rgem_pkg

interface rgem_pix_if import rgem_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  modport source (output valid, mode, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface rgem_res_if import rgem_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              edge_res;
  logic              frame_end;
  modport source (output valid, red_out, green_out, blue_out, edge_res, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, edge_res, frame_end,
                  output ready);
endinterface

interface rgem_cfg_if import rgem_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rgem_front.sv =====
`timescale 1ns / 1ps
// rgem_front: raster counters, two column-indexed line memories, neighbor
// gather and largest squared difference; depends on rgem_pkg, rgem_ifs

module rgem_front import rgem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_W,
  parameter int MAX_HEIGHT = DEF_MAX_H,
  localparam int IDX_W  = $clog2(MAX_WIDTH),
  localparam int ROW_W  = $clog2(MAX_HEIGHT),
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1),
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rgem_pix_if.sink              pix_i,
  input  logic                  restart_i,
  input  logic [WDIM_W-1:0]     width_i,
  input  logic [HDIM_W-1:0]     height_i,
  input  logic [FIFO_CNT_W-1:0] free_i,
  output logic                  push_o,
  output qent_t                 entry_o
);

  logic [IDX_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             full_q;

  // line memories: a holds the newest row per column, b the one before
  pixel_t line_a_q [MAX_WIDTH];
  pixel_t line_b_q [MAX_WIDTH];
  pixel_t rd_c_q, rd_r_q, rd_u_q, left_q;

  logic             f1_v_q, f1_emit_q, f1_wr_q;
  logic [IDX_W-1:0] f1_col_q;
  logic             f1_hl_q, f1_hr_q, f1_hu_q, f1_last_q;
  pixel_t           f1_cur_q;

  logic             acc, pix_wr, drain_em, emit, col_end, row_end;
  logic [IDX_W-1:0] col_p1;
  pixel_t           pix_in;

  assign pix_i.ready = free_i > FIFO_CNT_W'(f1_emit_q);
  assign acc      = pix_i.valid && pix_i.ready;
  assign pix_wr   = acc && !pix_i.mode && !full_q;
  assign drain_em = acc && pix_i.mode && full_q;
  assign emit     = drain_em || (pix_wr && (row_q != '0));
  assign col_end  = (WDIM_W'(col_q) + WDIM_W'(1)) == width_i;
  assign row_end  = (HDIM_W'(row_q) + HDIM_W'(1)) == height_i;
  assign col_p1   = col_q + IDX_W'(1);
  assign pix_in   = {pix_i.blue_in, pix_i.green_in, pix_i.red_in};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      full_q    <= 1'b0;
      f1_v_q    <= 1'b0;
      f1_emit_q <= 1'b0;
      f1_wr_q   <= 1'b0;
    end else begin
      f1_v_q    <= pix_wr || drain_em;
      f1_emit_q <= emit;
      f1_wr_q   <= pix_wr;
      if (restart_i) begin
        col_q  <= '0;
        row_q  <= '0;
        full_q <= 1'b0;
      end else if (pix_wr) begin
        if (col_end) begin
          col_q <= '0;
          if (row_end) full_q <= 1'b1;
          else row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_p1;
        end
      end else if (drain_em) begin
        if (col_end) begin
          col_q  <= '0;
          row_q  <= '0;
          full_q <= 1'b0;
        end else begin
          col_q <= col_p1;
        end
      end
    end
  end

  // stage one payload and memory ports
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_c_q    <= line_a_q[col_q];
      rd_r_q    <= line_a_q[col_p1];
      rd_u_q    <= line_b_q[col_q];
      f1_col_q  <= col_q;
      f1_cur_q  <= pix_in;
      f1_hl_q   <= col_q != '0;
      f1_hr_q   <= !col_end;
      f1_hu_q   <= pix_i.mode || (row_q > ROW_W'(1));
      f1_last_q <= pix_i.mode && col_end;
    end
    if (pix_wr) line_a_q[col_q] <= pix_in;
    if (f1_wr_q) line_b_q[f1_col_q] <= rd_c_q;
    if (f1_v_q) left_q <= rd_c_q;
  end

  pixel_t           nb_l, nb_r, nb_u, nb_d;
  logic [CHAN_W-1:0] dmax;

  always_comb begin
    logic [CHAN_W-1:0] gx, gy;
    nb_l = f1_hl_q ? left_q : rd_c_q;
    nb_r = f1_hr_q ? rd_r_q : rd_c_q;
    nb_u = f1_hu_q ? rd_u_q : rd_c_q;
    nb_d = f1_last_q || !f1_wr_q ? rd_c_q : f1_cur_q;
    dmax = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      gx = absdiff(nb_r[c], nb_l[c]);
      gy = absdiff(nb_d[c], nb_u[c]);
      if (gx > dmax) dmax = gx;
      if (gy > dmax) dmax = gy;
    end
  end

  assign push_o         = f1_v_q && f1_emit_q;
  assign entry_o.center = rd_c_q;
  assign entry_o.dsq    = SQ_W'(dmax) * SQ_W'(dmax);
  assign entry_o.last   = f1_last_q;

endmodule

// ===== rtl/rgem_fifo.sv =====
`timescale 1ns / 1ps
// rgem_fifo: short register queue between front and back
// depends on rgem_pkg

module rgem_fifo import rgem_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  qent_t                 entry_i,
  input  logic                  pop_i,
  output qent_t                 entry_o,
  output logic                  avail_o,
  output logic [FIFO_CNT_W-1:0] free_o
);

  qent_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_q, rp_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + FIFO_PTR_W'(1);
      if (pop_i) rp_q <= rp_q + FIFO_PTR_W'(1);
      cnt_q <= cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= entry_i;
  end

  assign entry_o = mem_q[rp_q];
  assign avail_o = cnt_q != '0;
  assign free_o  = FIFO_CNT_W'(FIFO_DEPTH) - cnt_q;

endmodule

// ===== rtl/rgem_back.sv =====
`timescale 1ns / 1ps
// rgem_back: threshold decision, marker color and the output register
// depends on rgem_pkg, rgem_ifs

module rgem_back import rgem_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qent_t             entry_i,
  input  logic              avail_i,
  output logic              pop_o,
  input  logic [CHAN_W-1:0] max_color_i,
  input  logic [SQ_W-1:0]   mc_sq_i,
  rgem_res_if.source        res_o
);

  logic valid_q, is_edge;

  // floor(m/2000) < d*d  <=>  m < 2000*d*d
  assign is_edge = (PROD_W'(entry_i.dsq) * PROD_W'(EDGE_DIVISOR)) > PROD_W'(mc_sq_i);
  assign pop_o   = avail_i && (!valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_o.red_out   <= is_edge ? max_color_i : entry_i.center[0];
      res_o.green_out <= is_edge ? '0 : entry_i.center[1];
      res_o.blue_out  <= is_edge ? max_color_i : entry_i.center[2];
      res_o.edge_res  <= is_edge;
      res_o.frame_end <= entry_i.last;
    end
  end

  assign res_o.valid = valid_q;

endmodule

// ===== rtl/rgb_gradient_edge_marker_unit.sv =====
`timescale 1ns / 1ps
// rgb_gradient_edge_marker_unit: top level, configuration registers and wiring
// depends on rgem_pkg, rgem_ifs, rgem_front, rgem_fifo, rgem_back

// Marks edges in an RGB frame streamed in raster order. Each word on pix_i is
// a pixel (mode 0) or a drain tick (mode 1). The result for a pixel leaves
// once the pixel one row below has arrived; after the last pixel of a frame,
// frame_width drain ticks flush the final row, the last result carrying
// frame_end. A pixel is marked magenta (max_color, 0, max_color) when the
// largest squared per-channel central difference (one-sided on the frame
// border) exceeds floor(max_color^2 / 2000); otherwise it passes unchanged.
// Pixels while flushing and drain ticks before the frame is complete are
// taken and dropped. One word is taken every clock while the queue has room;
// a result passes the stage-one registers, the queue and the output register.
// The four-deep queue between the gradient front end and the output stage
// lets either side stall alone. Writing frame_width or frame_height restarts
// the frame; geometry is clamped to [2, MAX_WIDTH] and [2, MAX_HEIGHT].
// Configure only while idle. No clearing pass is needed after reset.

module rgb_gradient_edge_marker_unit import rgem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_W,
  parameter int MAX_HEIGHT = DEF_MAX_H
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rgem_cfg_if.sink   cfg_i,
  rgem_pix_if.sink   pix_i,
  rgem_res_if.source res_o
);

  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

  logic [WDIM_W-1:0] width_q;
  logic [HDIM_W-1:0] height_q;
  logic [CHAN_W-1:0] max_color_q;
  logic [SQ_W-1:0]   mc_sq_q;
  logic [WDIM_W-1:0] width_d;
  logic [HDIM_W-1:0] height_d;
  logic              cfg_wr, restart;
  cfg_reg_e          cfg_sel;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;
  assign cfg_sel     = cfg_reg_e'(cfg_i.index);

  // clamp geometry into the supported range
  always_comb begin
    if (cfg_i.data < CFG_DATA_W'(2)) width_d = WDIM_W'(2);
    else if (32'(cfg_i.data) > 32'(MAX_WIDTH)) width_d = WDIM_W'(MAX_WIDTH);
    else width_d = WDIM_W'(cfg_i.data);
    if (cfg_i.data < CFG_DATA_W'(2)) height_d = HDIM_W'(2);
    else if (32'(cfg_i.data) > 32'(MAX_HEIGHT)) height_d = HDIM_W'(MAX_HEIGHT);
    else height_d = HDIM_W'(cfg_i.data);
  end

  assign restart = cfg_wr && (cfg_sel == REG_WIDTH || cfg_sel == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WDIM_W'(RST_WIDTH);
      height_q    <= HDIM_W'(RST_HEIGHT);
      max_color_q <= CHAN_W'(RST_MAXCOL);
      mc_sq_q     <= SQ_W'(RST_MAXCOL * RST_MAXCOL);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WIDTH:  width_q <= width_d;
        REG_HEIGHT: height_q <= height_d;
        REG_MAXCOL: begin
          max_color_q <= cfg_i.data[CHAN_W-1:0];
          mc_sq_q     <= SQ_W'(cfg_i.data[CHAN_W-1:0]) * SQ_W'(cfg_i.data[CHAN_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  logic                  push, pop, avail;
  logic [FIFO_CNT_W-1:0] free;
  qent_t                 push_ent, pop_ent;

  rgem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .restart_i (restart),
    .width_i   (width_q),
    .height_i  (height_q),
    .free_i    (free),
    .push_o    (push),
    .entry_o   (push_ent)
  );

  rgem_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_ent),
    .pop_i   (pop),
    .entry_o (pop_ent),
    .avail_o (avail),
    .free_o  (free)
  );

  rgem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (pop_ent),
    .avail_i     (avail),
    .pop_o       (pop),
    .max_color_i (max_color_q),
    .mc_sq_i     (mc_sq_q),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/rgem_checker.sv =====
`timescale 1ns / 1ps
// rgem_checker: port-level checks on the result channel, bound to the top
// depends on rgem_pkg, rgb_gradient_edge_marker_unit

module rgem_checker import rgem_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              ready_i,
  input logic [CHAN_W-1:0] red_i,
  input logic [CHAN_W-1:0] green_i,
  input logic [CHAN_W-1:0] blue_i,
  input logic              edge_i,
  input logic              fend_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result word dropped while stalled");

  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable({red_i, green_i, blue_i, edge_i, fend_i}))
    else $error("result word changed while stalled");

  a_marker_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && edge_i |-> green_i == '0)
    else $error("marked pixel has green");

  a_marker_magenta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && edge_i |-> red_i == blue_i)
    else $error("marked pixel red and blue differ");

endmodule

bind rgb_gradient_edge_marker_unit rgem_checker u_rgem_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (res_o.valid),
  .ready_i (res_o.ready),
  .red_i   (res_o.red_out),
  .green_i (res_o.green_out),
  .blue_i  (res_o.blue_out),
  .edge_i  (res_o.edge_res),
  .fend_i  (res_o.frame_end)
);
